>>> hdl/lrhm_pkg.sv
package lrhm_pkg;

	// widths of the pixel and luma fields
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned LUMA_W = 16;

	// bt.601 luma weights in q8, offset is 16 << 8
	localparam logic [LUMA_W-1:0] COEF_R      = 16'd66;
	localparam logic [LUMA_W-1:0] COEF_G      = 16'd129;
	localparam logic [LUMA_W-1:0] COEF_B      = 16'd25;
	localparam logic [LUMA_W-1:0] LUMA_OFFSET = 16'd4096;

	// reset values of the tracked range and of the face byte
	localparam logic [LUMA_W-1:0] LUMA_MIN_INIT = '1;
	localparam logic [LUMA_W-1:0] LUMA_MAX_INIT = '0;
	localparam logic [CHAN_W-1:0] FACE_INIT     = 8'd255;

	// floor(x / 5) for x below 2^18 as (x * RECIP5) >> RECIP5_SHIFT
	localparam int unsigned       SPREAD4_W    = LUMA_W + 2;
	localparam int unsigned       RECIP5_W     = 16;
	localparam int unsigned       RECIP5_SHIFT = 18;
	localparam logic [RECIP5_W-1:0] RECIP5     = 16'd52429;

	// pass selector
	typedef enum logic {
		FUNC_GATHER   = 1'b0,
		FUNC_CLASSIFY = 1'b1
	} func_t;

	// contents of the input register
	typedef struct packed {
		func_t             func;
		logic              first;
		logic              face;
		logic [LUMA_W-1:0] luma;
	} pix_item_t;

	// q8 luma, never above 60196 so it fits 16 bits
	function automatic logic [LUMA_W-1:0] calc_luma(
		input logic [CHAN_W-1:0] r,
		input logic [CHAN_W-1:0] g,
		input logic [CHAN_W-1:0] b
	);
		logic [LUMA_W-1:0] rr;
		logic [LUMA_W-1:0] gg;
		logic [LUMA_W-1:0] bb;
		rr = {{(LUMA_W-CHAN_W){1'b0}}, r};
		gg = {{(LUMA_W-CHAN_W){1'b0}}, g};
		bb = {{(LUMA_W-CHAN_W){1'b0}}, b};
		return LUMA_W'(COEF_R * rr + COEF_G * gg + COEF_B * bb + LUMA_OFFSET);
	endfunction

endpackage

>>> hdl/luma_relative_highlight_mark_unit.sv
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------
// input     | in        | in_valid / in_stall    | func first red green blue mask_value
// result    | out       | out_valid / out_stall  | candidate luma
// config    | in        | cfg_valid / cfg_ready  | cfg_data (face_value)
//
// one pixel beat is taken per clock while in_stall is low; a classify beat moves on
// into the result register, a gather beat gives none and only updates the luma range.
// the luma range and the threshold sit between the input register and the
// result register, so a classify beat right after a gather beat sees its update.
// arst_n clears valids, the luma range (min all ones, max zero) and face_value (255).
// out_stall holds the result register; in_stall rises only when the input register
// holds a classify beat that cannot move into the full, stalled result register.
module luma_relative_highlight_mark_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	// pixel input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic                         first,
	input  logic [lrhm_pkg::CHAN_W-1:0]  red,
	input  logic [lrhm_pkg::CHAN_W-1:0]  green,
	input  logic [lrhm_pkg::CHAN_W-1:0]  blue,
	input  logic [lrhm_pkg::CHAN_W-1:0]  mask_value,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         candidate,
	output logic [lrhm_pkg::LUMA_W-1:0]  luma,
	// configuration channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lrhm_pkg::CHAN_W-1:0]  cfg_data
);
	import lrhm_pkg::*;

	logic [CHAN_W-1:0]     face_value_q;
	pix_item_t             item_s1;
	logic                  valid_s1;
	logic [LUMA_W-1:0]     luma_min_q;
	logic [LUMA_W-1:0]     luma_max_q;
	logic                  out_valid_q;
	logic                  cand_s2;
	logic [LUMA_W-1:0]     luma_s2;

	logic                  in_take;
	logic                  adv_s1;
	logic                  out_free;
	pix_item_t             item_in;
	logic [LUMA_W-1:0]     base_min;
	logic [LUMA_W-1:0]     base_max;
	logic [LUMA_W-1:0]     spread;
	logic [SPREAD4_W-1:0]  spread4;
	logic [SPREAD4_W+RECIP5_W-1:0] frac_prod;
	logic [LUMA_W-1:0]     frac;
	logic [LUMA_W-1:0]     thd;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_value_q <= FACE_INIT;
		end else if (cfg_valid && cfg_ready) begin
			face_value_q <= cfg_data;
		end
	end

	// handshake: input register moves on unless a classify beat is blocked
	assign out_free = !out_valid_q || !out_stall;
	assign adv_s1   = valid_s1 && ((item_s1.func == FUNC_GATHER) || out_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	// luma and face match computed on the way into the input register
	always_comb begin
		item_in.func  = func_t'(func);
		item_in.first = first;
		item_in.face  = (mask_value == face_value_q);
		item_in.luma  = calc_luma(red, green, blue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	// gather: range after an optional restart on the first pixel
	always_comb begin
		base_min = item_s1.first ? LUMA_MIN_INIT : luma_min_q;
		base_max = item_s1.first ? LUMA_MAX_INIT : luma_max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_min_q <= LUMA_MIN_INIT;
			luma_max_q <= LUMA_MAX_INIT;
		end else if (adv_s1 && (item_s1.func == FUNC_GATHER)) begin
			luma_min_q <= (item_s1.face && (item_s1.luma < base_min)) ? item_s1.luma : base_min;
			luma_max_q <= (item_s1.face && (item_s1.luma > base_max)) ? item_s1.luma : base_max;
		end
	end

	// classify: threshold = min + floor(spread * 4 / 5), empty range gives zero spread
	always_comb begin
		spread    = (luma_max_q > luma_min_q) ? (luma_max_q - luma_min_q) : '0;
		spread4   = {spread, 2'b00};
		frac_prod = {{RECIP5_W{1'b0}}, spread4} * {{SPREAD4_W{1'b0}}, RECIP5};
		frac      = frac_prod[RECIP5_SHIFT +: LUMA_W];
		thd       = luma_min_q + frac;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && (item_s1.func == FUNC_CLASSIFY)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && (item_s1.func == FUNC_CLASSIFY)) begin
			cand_s2 <= item_s1.face && (item_s1.luma > thd);
			luma_s2 <= item_s1.luma;
		end
	end

	assign out_valid = out_valid_q;
	assign candidate = cand_s2;
	assign luma      = luma_s2;

	// a nonzero max means a face pixel was gathered, so min cannot exceed it
	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(luma_max_q != '0) |-> (luma_min_q <= luma_max_q))
		else $error("luma range out of order");

	// a classify beat leaving the input register must show up as a result
	a_classify_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && (item_s1.func == FUNC_CLASSIFY)) |=> out_valid_q)
		else $error("classify beat lost");

	// input stalls only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without cause");

endmodule

>>> tb/highlight_mark_checker.sv
`timescale 1ns / 1ps

module highlight_mark_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel channel
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic                        func,
	input  logic                        first,
	input  logic [lrhm_pkg::CHAN_W-1:0] red,
	input  logic [lrhm_pkg::CHAN_W-1:0] green,
	input  logic [lrhm_pkg::CHAN_W-1:0] blue,
	input  logic [lrhm_pkg::CHAN_W-1:0] mask_value,
	// result channel
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic                        candidate,
	input  logic [lrhm_pkg::LUMA_W-1:0] luma,
	// face byte write channel
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [lrhm_pkg::CHAN_W-1:0] cfg_data,
	output int                          fail_count,
	output int                          pending_count
);
	import lrhm_pkg::*;

	typedef struct packed {
		logic              mark;
		logic [LUMA_W-1:0] level;
	} mark_beat_t;

	// marks predicted for accepted classify beats, oldest first
	mark_beat_t        pending_marks[$];
	logic [LUMA_W-1:0] range_lo;
	logic [LUMA_W-1:0] range_hi;
	logic [CHAN_W-1:0] face_sel;
	int                errs;

	// follow every handshake, predict on pixel beats and compare result beats
	always @(posedge clk or negedge arst_n) begin
		mark_beat_t  want;
		mark_beat_t  got;
		int unsigned y;
		int unsigned spread;
		int unsigned thd;
		logic        is_face;
		if (!arst_n) begin
			pending_marks.delete();
			range_lo      = '1;
			range_hi      = '0;
			face_sel      = 8'd255;
			errs          = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			// face byte write
			if (cfg_valid && cfg_ready)
				face_sel = cfg_data;

			// result beat against the oldest prediction
			if (out_valid && !out_stall) begin
				got.mark  = candidate;
				got.level = luma;
				if (pending_marks.size() == 0) begin
					$display("%0t: result beat with none expected: candidate %0b luma %0d",
						$time, candidate, luma);
					errs++;
				end else begin
					want = pending_marks.pop_front();
					if (got.mark !== want.mark) begin
						$display("%0t: candidate mismatch: expected %0b actual %0b",
							$time, want.mark, got.mark);
						errs++;
					end
					if (got.level !== want.level) begin
						$display("%0t: luma mismatch: expected %0d actual %0d",
							$time, want.level, got.level);
						errs++;
					end
				end
			end

			// pixel beat: q8 bt.601 luma, then range update or mark
			if (in_valid && !in_stall) begin
				is_face = (mask_value == face_sel);
				y = 66 * red + 129 * green + 25 * blue + 4096;
				if (func_t'(func) == FUNC_GATHER) begin
					if (first) begin
						range_lo = '1;
						range_hi = '0;
					end
					if (is_face) begin
						if (y < range_lo)
							range_lo = y[LUMA_W-1:0];
						if (y > range_hi)
							range_hi = y[LUMA_W-1:0];
					end
				end else begin
					// empty range counts as zero spread
					spread = (range_hi > range_lo) ? range_hi - range_lo : 0;
					thd = range_lo + (spread * 4) / 5;
					want.mark  = is_face && (y > thd);
					want.level = y[LUMA_W-1:0];
					pending_marks.push_back(want);
				end
			end

			fail_count    <= errs;
			pending_count <= pending_marks.size();
		end
	end

endmodule

>>> tb/tb_luma_relative_highlight_mark_unit.sv
`timescale 1ns / 1ps

module tb_luma_relative_highlight_mark_unit;
	import lrhm_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_PIXELS  = 700;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              func;
	logic              first;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
	logic [CHAN_W-1:0] mask_value;
	logic              out_valid;
	logic              out_stall;
	logic              candidate;
	logic [LUMA_W-1:0] luma;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CHAN_W-1:0] cfg_data;

	int                fail_count;
	int                pending_count;
	int                snd_idle_pct;
	int                rcv_stall_pct;
	int                quiet_cycles;
	logic [CHAN_W-1:0] face_now;

	luma_relative_highlight_mark_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.first      (first),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.mask_value (mask_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.candidate  (candidate),
		.luma       (luma),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	highlight_mark_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.first         (first),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.mask_value    (mask_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.candidate     (candidate),
		.luma          (luma),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side stalls at random
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	// no beat on any channel for too long ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one pixel beat, with a random gap ahead of it
	task automatic push_pixel(input func_t f, input logic fst, input logic [CHAN_W-1:0] r,
			input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b,
			input logic [CHAN_W-1:0] m);
		// each cycle ahead of the beat is idle with the sender idle percentage
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		first      <= fst;
		red        <= r;
		green      <= g;
		blue       <= b;
		mask_value <= m;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off until every mark is back and the pipe has emptied
	task automatic drain_block();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_face(input logic [CHAN_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		face_now = v;
	endtask

	// mostly the current face byte, otherwise anything
	function automatic logic [CHAN_W-1:0] pick_mask();
		if ($urandom_range(0, 99) < 60)
			return face_now;
		return 8'($urandom_range(0, 255));
	endfunction

	// gather then classify frames with random content, some stray beats between
	task automatic run_frames(input int n_pixels);
		int sent;
		int n_gather;
		int n_class;
		sent = 0;
		while (sent < n_pixels) begin
			if ($urandom_range(0, 9) == 0) begin
				push_pixel(func_t'(1'($urandom_range(0, 1))), 1'($urandom_range(0, 1)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), pick_mask());
				sent++;
			end else begin
				n_gather = $urandom_range(1, 10);
				n_class  = $urandom_range(1, 10);
				for (int i = 0; i < n_gather; i++)
					push_pixel(FUNC_GATHER, (i == 0) || ($urandom_range(0, 49) == 0),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), pick_mask());
				for (int i = 0; i < n_class; i++)
					push_pixel(FUNC_CLASSIFY, 1'($urandom_range(0, 1)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), pick_mask());
				sent += n_gather + n_class;
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		func          <= FUNC_GATHER;
		first         <= 1'b0;
		red           <= '0;
		green         <= '0;
		blue          <= '0;
		mask_value    <= '0;
		cfg_valid     <= 1'b0;
		cfg_data      <= '0;
		snd_idle_pct  <= 31;
		rcv_stall_pct <= 64;
		face_now      = 8'd255;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// classify straight after reset: empty range, nothing marked
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
		// first flag on a non-face pixel only clears the range
		push_pixel(FUNC_GATHER,   1'b1, 8'd10,  8'd20,  8'd30,  8'd0);
		push_pixel(FUNC_CLASSIFY, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
		// full range, black to white
		push_pixel(FUNC_GATHER,   1'b1, 8'd0,   8'd0,   8'd0,   8'd255);
		push_pixel(FUNC_GATHER,   1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
		push_pixel(FUNC_GATHER,   1'b0, 8'd0,   8'd0,   8'd0,   8'd254);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd0,   8'd0,   8'd0,   8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd255, 8'd0,   8'd0,   8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd0,   8'd255, 8'd0,   8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd0,   8'd0,   8'd255, 8'd255);
		// first flag ignored while classifying
		push_pixel(FUNC_CLASSIFY, 1'b1, 8'd255, 8'd255, 8'd0,   8'd255);
		// single face pixel: luma equal to threshold is not marked
		push_pixel(FUNC_GATHER,   1'b1, 8'd128, 8'd128, 8'd128, 8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd128, 8'd128, 8'd128, 8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd129, 8'd128, 8'd128, 8'd255);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd127, 8'd128, 8'd128, 8'd255);
		// face byte zero
		drain_block();
		write_face(8'd0);
		push_pixel(FUNC_GATHER,   1'b1, 8'd0,   8'd0,   8'd0,   8'd0);
		push_pixel(FUNC_GATHER,   1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0);
		push_pixel(FUNC_CLASSIFY, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255);

		// random frames under three idling mixes
		for (int p = 0; p < 3; p++) begin
			drain_block();
			snd_idle_pct  <= (p == 0) ? 31 : (p == 1) ? 64 : 0;
			rcv_stall_pct <= (p == 0) ? 64 : (p == 1) ? 31 : 0;
			write_face((p == 2) ? 8'd255 : 8'($urandom_range(1, 254)));
			run_frames(RANDOM_PIXELS / 6);
			drain_block();
			write_face((p == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
			run_frames(RANDOM_PIXELS / 6);
		end

		drain_block();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hdl/lrhm_pkg.sv
hdl/luma_relative_highlight_mark_unit.sv
tb/highlight_mark_checker.sv
tb/tb_luma_relative_highlight_mark_unit.sv
